[src/ddp_pkg.sv]
// Shared widths, constants, codes and stage types for the differential drive PID.
package ddp_pkg;

	// Field and register widths
	localparam int ERR_W      = 16;
	localparam int FRAC_W     = 8;
	localparam int GAIN_W     = 16;
	localparam int PWM_W      = 10;
	localparam int DRV_W      = 11;
	localparam int TGT_W      = 9;
	localparam int HEAD_W     = 17;
	localparam int ANG_FRAC_W = 8;
	localparam int DINT_W     = 32;
	localparam int RINT_W     = 24;
	localparam int RERR_W     = 9;
	localparam int CFG_IDX_W  = 3;

	// Heading difference in 1/256 degree: target scaled minus heading, one bit of growth
	localparam int DIFF_W = HEAD_W + 1;
	localparam logic signed [DIFF_W-1:0] HALF_TURN_Q8 = DIFF_W'(180 * (1 << ANG_FRAC_W));
	localparam logic signed [DIFF_W-1:0] FULL_TURN_Q8 = DIFF_W'(360 * (1 << ANG_FRAC_W));
	localparam int ROT_E_MAX = 180;

	// Distance loop drive limit is pwm_max less this margin
	localparam logic [PWM_W-1:0] DIST_MARGIN = PWM_W'(50);

	// Product and sum widths (gain taken as a non-negative signed operand)
	localparam int P_E_W = GAIN_W + 1 + ERR_W;
	localparam int P_I_W = GAIN_W + 1 + DINT_W;
	localparam int P_D_W = GAIN_W + 1 + ERR_W + 1;
	localparam int SUM_W = P_I_W + 2;

	typedef enum logic [1:0] {
		CMD_DIST     = 2'd0,
		CMD_ROT      = 2'd1,
		CMD_CLR_DIST = 2'd2,
		CMD_CLR_ROT  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_DIST = 3'd0,
		REG_KI_DIST = 3'd1,
		REG_KD_DIST = 3'd2,
		REG_KP_ANG  = 3'd3,
		REG_KI_ANG  = 3'd4,
		REG_KD_ANG  = 3'd5,
		REG_PWM_MAX = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp_dist;
		logic [GAIN_W-1:0] ki_dist;
		logic [GAIN_W-1:0] kd_dist;
		logic [GAIN_W-1:0] kp_ang;
		logic [GAIN_W-1:0] ki_ang;
		logic [GAIN_W-1:0] kd_ang;
		logic [PWM_W-1:0]  pwm_max;
	} gains_t;

	// Error stage result: error, difference and updated integrator of one loop
	typedef struct packed {
		cmd_t                     cmd;
		logic signed [ERR_W-1:0]  e;
		logic signed [ERR_W:0]    d;
		logic signed [DINT_W-1:0] integ;
	} err_item_t;

	// Product stage result: the three gain products
	typedef struct packed {
		cmd_t                    cmd;
		logic signed [P_E_W-1:0] p_e;
		logic signed [P_I_W-1:0] p_i;
		logic signed [P_D_W-1:0] p_d;
	} prod_item_t;

endpackage

[src/ddp_cfg.sv]
// Configuration register file: gains and drive limit.
module ddp_cfg import ddp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	output gains_t               gains
);

	gains_t gains_q;

	assign cfg_ready = 1'b1;
	assign gains     = gains_q;

	// Write one register per transfer; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp_dist <= GAIN_W'(256);
			gains_q.ki_dist <= '0;
			gains_q.kd_dist <= '0;
			gains_q.kp_ang  <= GAIN_W'(256);
			gains_q.ki_ang  <= '0;
			gains_q.kd_ang  <= '0;
			gains_q.pwm_max <= PWM_W'(255);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KP_DIST: gains_q.kp_dist <= cfg_data;
				REG_KI_DIST: gains_q.ki_dist <= cfg_data;
				REG_KD_DIST: gains_q.kd_dist <= cfg_data;
				REG_KP_ANG:  gains_q.kp_ang  <= cfg_data;
				REG_KI_ANG:  gains_q.ki_ang  <= cfg_data;
				REG_KD_ANG:  gains_q.kd_ang  <= cfg_data;
				REG_PWM_MAX: gains_q.pwm_max <= cfg_data[PWM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[src/ddp_err.sv]
// Input register, heading wrap, and per-loop error, derivative and integrator state.
module ddp_err import ddp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic signed [ERR_W-1:0]  distance_error,
	input  logic signed [TGT_W-1:0]  target_angle,
	input  logic signed [HEAD_W-1:0] robot_heading,
	output logic                     dn_valid,
	input  logic                     dn_ready,
	output err_item_t                dn_item
);

	// Input register
	logic                     v_s1;
	cmd_t                     cmd_s1;
	logic signed [ERR_W-1:0]  derr_s1;
	logic signed [TGT_W-1:0]  tgt_s1;
	logic signed [HEAD_W-1:0] head_s1;

	// Loop state
	logic signed [DINT_W-1:0] dist_int_q;
	logic signed [ERR_W-1:0]  dist_last_q;
	logic signed [RINT_W-1:0] rot_int_q;
	logic signed [RERR_W-1:0] rot_last_q;

	// Error stage register
	logic      v_s2;
	err_item_t item_s2;

	logic adv2;
	logic acc;

	logic signed [DIFF_W-1:0] tgt_q8;
	logic signed [DIFF_W-1:0] diff_raw;
	logic signed [DIFF_W-1:0] diff_wrap;
	logic signed [DIFF_W-1:0] diff_sh;
	logic                     round_up;
	logic signed [RERR_W-1:0] e_rot;
	logic signed [RERR_W:0]   d_rot;
	logic signed [RINT_W:0]   rint_sum;
	logic signed [RINT_W-1:0] rint_next;

	logic signed [ERR_W:0]    d_dist;
	logic signed [DINT_W:0]   dint_sum;
	logic signed [DINT_W-1:0] dint_next;

	err_item_t item_next;

	// Pipeline control: the input stage frees up when its item moves on
	assign adv2     = v_s1 && (!v_s2 || dn_ready);
	assign in_ready = !v_s1 || adv2;
	assign acc      = in_valid && in_ready;
	assign dn_valid = v_s2;
	assign dn_item  = item_s2;

	// Hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= cmd_t'(cmd);
			derr_s1 <= distance_error;
			tgt_s1  <= target_angle;
			head_s1 <= robot_heading;
		end
	end

	// Wrap heading difference into a half turn and truncate toward zero to degrees
	always_comb begin
		tgt_q8   = DIFF_W'(tgt_s1) <<< ANG_FRAC_W;
		diff_raw = tgt_q8 - DIFF_W'(head_s1);
		if (diff_raw > HALF_TURN_Q8) begin
			diff_wrap = diff_raw - FULL_TURN_Q8;
		end else if (diff_raw < -HALF_TURN_Q8) begin
			diff_wrap = diff_raw + FULL_TURN_Q8;
		end else begin
			diff_wrap = diff_raw;
		end
		diff_sh  = diff_wrap >>> ANG_FRAC_W;
		round_up = diff_wrap[DIFF_W-1] && (diff_wrap[ANG_FRAC_W-1:0] != '0);
		e_rot    = RERR_W'(diff_sh) + RERR_W'(round_up);
	end

	// Rotation derivative and saturating integrator
	always_comb begin
		d_rot    = (RERR_W+1)'(e_rot) - (RERR_W+1)'(rot_last_q);
		rint_sum = (RINT_W+1)'(rot_int_q) + (RINT_W+1)'(e_rot);
		if (rint_sum[RINT_W] != rint_sum[RINT_W-1]) begin
			rint_next = rint_sum[RINT_W] ? {1'b1, {(RINT_W-1){1'b0}}}
			                             : {1'b0, {(RINT_W-1){1'b1}}};
		end else begin
			rint_next = rint_sum[RINT_W-1:0];
		end
	end

	// Distance derivative and saturating integrator
	always_comb begin
		d_dist   = (ERR_W+1)'(derr_s1) - (ERR_W+1)'(dist_last_q);
		dint_sum = (DINT_W+1)'(dist_int_q) + (DINT_W+1)'(derr_s1);
		if (dint_sum[DINT_W] != dint_sum[DINT_W-1]) begin
			dint_next = dint_sum[DINT_W] ? {1'b1, {(DINT_W-1){1'b0}}}
			                             : {1'b0, {(DINT_W-1){1'b1}}};
		end else begin
			dint_next = dint_sum[DINT_W-1:0];
		end
	end

	// Select the active loop's terms
	always_comb begin
		item_next.cmd = cmd_s1;
		case (cmd_s1)
			CMD_DIST: begin
				item_next.e     = derr_s1;
				item_next.d     = d_dist;
				item_next.integ = dint_next;
			end
			CMD_ROT: begin
				item_next.e     = ERR_W'(e_rot);
				item_next.d     = (ERR_W+1)'(d_rot);
				item_next.integ = DINT_W'(rint_next);
			end
			default: begin
				item_next.e     = '0;
				item_next.d     = '0;
				item_next.integ = '0;
			end
		endcase
	end

	// Update loop state as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_int_q  <= '0;
			dist_last_q <= '0;
			rot_int_q   <= '0;
			rot_last_q  <= '0;
		end else if (adv2) begin
			case (cmd_s1)
				CMD_DIST: begin
					dist_int_q  <= dint_next;
					dist_last_q <= derr_s1;
				end
				CMD_ROT: begin
					rot_int_q  <= rint_next;
					rot_last_q <= e_rot;
				end
				CMD_CLR_DIST: begin
					dist_int_q  <= '0;
					dist_last_q <= '0;
				end
				CMD_CLR_ROT: begin
					rot_int_q  <= '0;
					rot_last_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Advance the error stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || dn_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			item_s2 <= item_next;
		end
	end

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1)
		else $error("input stalled with an empty input register");

	a_clr_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && cmd_s1 == CMD_CLR_DIST) |=> (dist_int_q == '0 && dist_last_q == '0))
		else $error("distance loop state not cleared");

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && item_s2.cmd == CMD_ROT) |-> (item_s2.e <= ROT_E_MAX && item_s2.e >= -ROT_E_MAX))
		else $error("wrapped heading error outside a half turn");
`endif

endmodule

[src/ddp_mul.sv]
// Gain product stage: three signed products of the selected loop's gains.
module ddp_mul import ddp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  gains_t     gains,
	input  logic       up_valid,
	output logic       up_ready,
	input  err_item_t  up_item,
	output logic       dn_valid,
	input  logic       dn_ready,
	output prod_item_t dn_item
);

	logic       v_s3;
	prod_item_t item_s3;
	prod_item_t item_next;

	logic [GAIN_W-1:0] kp;
	logic [GAIN_W-1:0] ki;
	logic [GAIN_W-1:0] kd;

	assign up_ready = !v_s3 || dn_ready;
	assign dn_valid = v_s3;
	assign dn_item  = item_s3;

	// Pick the gain set of the loop in use
	always_comb begin
		case (up_item.cmd)
			CMD_ROT, CMD_CLR_ROT: begin
				kp = gains.kp_ang;
				ki = gains.ki_ang;
				kd = gains.kd_ang;
			end
			default: begin
				kp = gains.kp_dist;
				ki = gains.ki_dist;
				kd = gains.kd_dist;
			end
		endcase
	end

	// Multiply each term by its gain at full width
	always_comb begin
		item_next.cmd = up_item.cmd;
		item_next.p_e = P_E_W'($signed({1'b0, kp})) * P_E_W'(up_item.e);
		item_next.p_i = P_I_W'($signed({1'b0, ki})) * P_I_W'(up_item.integ);
		item_next.p_d = P_D_W'($signed({1'b0, kd})) * P_D_W'(up_item.d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (up_ready) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_s3 <= item_next;
		end
	end

endmodule

[src/ddp_out.sv]
// Sum, scale, clamp and wheel drive result register.
module ddp_out import ddp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [PWM_W-1:0]        pwm_max,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  prod_item_t              up_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DRV_W-1:0] right_drive,
	output logic signed [DRV_W-1:0] left_drive
);

	logic                    out_valid_q;
	logic signed [DRV_W-1:0] right_q;
	logic signed [DRV_W-1:0] left_q;

	logic signed [SUM_W-1:0] sum;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W-1:0]        mag_sc;
	logic [PWM_W-1:0]        limit;
	logic [PWM_W-1:0]        drv_mag;
	logic signed [DRV_W-1:0] right_next;
	logic signed [DRV_W-1:0] left_next;
	logic                    load;

	assign up_ready    = !out_valid_q || out_ready;
	assign load        = up_valid && up_ready;
	assign out_valid   = out_valid_q;
	assign right_drive = right_q;
	assign left_drive  = left_q;

	// Add the products and scale the magnitude down, truncating toward zero
	always_comb begin
		sum    = SUM_W'(up_item.p_e) + SUM_W'(up_item.p_i) + SUM_W'(up_item.p_d);
		mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		mag_sc = mag >> FRAC_W;
	end

	// Clamp to the loop's limit and steer the wheels
	always_comb begin
		limit = pwm_max;
		if (up_item.cmd == CMD_DIST) begin
			limit = (pwm_max > DIST_MARGIN) ? pwm_max - DIST_MARGIN : '0;
		end
		drv_mag    = (mag_sc > SUM_W'(limit)) ? limit : mag_sc[PWM_W-1:0];
		right_next = sum[SUM_W-1] ? -DRV_W'(drv_mag) : DRV_W'(drv_mag);
		case (up_item.cmd)
			CMD_DIST: left_next = right_next;
			CMD_ROT:  left_next = -right_next;
			default: begin
				right_next = '0;
				left_next  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (up_ready) begin
			out_valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			right_q <= right_next;
			left_q  <= left_next;
		end
	end

`ifndef ASSERT_OFF
	a_clr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (up_item.cmd == CMD_CLR_DIST || up_item.cmd == CMD_CLR_ROT))
		|=> (right_q == '0 && left_q == '0))
		else $error("reset command gave a nonzero drive");

	a_dist_same: assert property (@(posedge clk) disable iff (!arst_n)
		(load && up_item.cmd == CMD_DIST) |=> (left_q == right_q))
		else $error("distance step drives the wheels unequally");

	a_rot_opp: assert property (@(posedge clk) disable iff (!arst_n)
		(load && up_item.cmd == CMD_ROT) |=> (left_q == -right_q))
		else $error("rotation step does not drive the wheels oppositely");
`endif

endmodule

[src/differential_drive_pid.sv]
// Top level of the two-loop differential drive PID controller.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    cmd, distance_error, target_angle, robot_heading
//   out      output     out_valid/out_ready  right_drive, left_drive
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a result passes through
// four registers (input register, error stage, product stage, result register).
// The loop integrators update as an item leaves the input register, which sets the
// one-item-per-cycle rate. Configuration writes are always accepted and are registered.
// Reset restores register defaults, clears both loops and empties the pipeline.
// Each stage holds its item under a stall; input is taken while any stage has room.
module differential_drive_pid import ddp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic signed [ERR_W-1:0]  distance_error,
	input  logic signed [TGT_W-1:0]  target_angle,
	input  logic signed [HEAD_W-1:0] robot_heading,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DRV_W-1:0]  right_drive,
	output logic signed [DRV_W-1:0]  left_drive,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data
);

	gains_t     gains;
	logic       err_valid;
	logic       err_ready;
	err_item_t  err_item;
	logic       prod_valid;
	logic       prod_ready;
	prod_item_t prod_item;

	// Configuration registers
	ddp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gains     (gains)
	);

	// Error terms and loop state
	ddp_err u_err (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.distance_error (distance_error),
		.target_angle   (target_angle),
		.robot_heading  (robot_heading),
		.dn_valid       (err_valid),
		.dn_ready       (err_ready),
		.dn_item        (err_item)
	);

	// Gain products
	ddp_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.gains    (gains),
		.up_valid (err_valid),
		.up_ready (err_ready),
		.up_item  (err_item),
		.dn_valid (prod_valid),
		.dn_ready (prod_ready),
		.dn_item  (prod_item)
	);

	// Sum, clamp and drive result
	ddp_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.pwm_max     (gains.pwm_max),
		.up_valid    (prod_valid),
		.up_ready    (prod_ready),
		.up_item     (prod_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.right_drive (right_drive),
		.left_drive  (left_drive)
	);

endmodule
